[hdl/cbdt_pkg.sv]
// Shared constants, codes and control structs of the city-block distance transform.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package cbdt_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int DIST_BITS  = 8;

    // Geometry registers are 8 bits wide whatever the frame maximum.
    localparam int DIM_BITS   = 8;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int X_BITS     = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int Y_BITS     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // APB map: two 32-bit registers at byte addresses 0 and 4.
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(128);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(128);

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_CLEAR,
        POS_INC,
        POS_DEC
    } pos_op_t;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_TOP,
        RD_BOT
    } rd_sel_t;

    typedef enum logic [1:0] {
        OUT_LOAD,
        OUT_READ,
        OUT_REJECT
    } out_kind_t;

    typedef enum logic {
        DIR_FWD,
        DIR_REV
    } pass_dir_t;

    typedef struct packed {
        pos_op_t   pos_op;
        rd_sel_t   rd_sel;
        logic      cur_load;
        logic      load_write;
        logic      pass_write;
        pass_dir_t pass_dir;
        logic      out_load;
        out_kind_t out_kind;
        logic      cfg_open;
    } cbdt_cmd_t;

    typedef struct packed {
        logic at_first;
        logic at_last;
        logic out_free;
    } cbdt_stat_t;

endpackage

[hdl/cbdt_if.sv]
// Valid/ready channel interfaces: the command word in and the result word out.
// Depends on cbdt_pkg for the distance width.
`timescale 1ns / 1ps

interface cbdt_pix_if;
    logic valid;
    logic ready;
    logic cmd;
    logic pixel_on;

    modport source (output valid, output cmd, output pixel_on, input ready);
    modport sink   (input valid, input cmd, input pixel_on, output ready);
endinterface

interface cbdt_res_if import cbdt_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [DIST_BITS-1:0] distance;
    logic                 last_pixel;
    logic                 status;

    modport source (output valid, output distance, output last_pixel, output status,
                    input ready);
    modport sink   (input valid, input distance, input last_pixel, input status,
                    output ready);
endinterface

[hdl/cbdt_datapath.sv]
// Datapath: geometry registers and APB port, position counters, distance store,
// pass arithmetic and result register. Depends on cbdt_pkg; driven by cbdt_ctrl.
`timescale 1ns / 1ps

module cbdt_datapath
    import cbdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cbdt_cmd_t             cmd,
    output cbdt_stat_t            stat,
    input  logic                  pixel_on,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [DIST_BITS-1:0]  distance,
    output logic                  last_pixel,
    output logic                  status
);

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
    localparam logic [DIM_BITS-1:0]  W_CAP = DIM_BITS'((MAX_WIDTH  > 255) ? 255 : MAX_WIDTH);
    localparam logic [DIM_BITS-1:0]  H_CAP = DIM_BITS'((MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT);
    localparam logic [DIM_BITS-1:0]  DIM_ONE = DIM_BITS'(1);

    function automatic logic [DIST_BITS-1:0] sat_inc(input logic [DIST_BITS-1:0] v);
        return (v == DIST_MAX) ? v : v + DIST_BITS'(1);
    endfunction

    function automatic logic [DIST_BITS-1:0] dmin(input logic [DIST_BITS-1:0] a,
                                                  input logic [DIST_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic [DIM_BITS-1:0]  width_reg, height_reg;
    logic [DIM_BITS-1:0]  eff_w, eff_h;
    logic [ADDR_BITS-1:0] pos_reg, pos_next;
    logic [X_BITS-1:0]    x_reg, x_next;
    logic [Y_BITS-1:0]    y_reg, y_next;
    logic                 x_first, x_last, y_first, y_last;
    logic                 cfg_we;

    logic [DIST_BITS-1:0] store_mem [DEPTH];
    logic [DIST_BITS-1:0] rdata_reg;
    logic [ADDR_BITS-1:0] raddr;
    logic                 mem_we;
    logic [DIST_BITS-1:0] mem_wdata;

    logic [DIST_BITS-1:0] cur_reg, nbr_reg;
    logic [DIST_BITS-1:0] side_v, vert_v, pass_val;

    logic                 out_valid_reg;
    logic [DIST_BITS-1:0] distance_reg;
    logic                 last_reg, status_reg;

    // Out-of-range geometry: zero acts as one, above the maximum acts as the maximum.
    always_comb
    begin
        if (width_reg == '0)
            eff_w = DIM_ONE;
        else if (width_reg > W_CAP)
            eff_w = W_CAP;
        else
            eff_w = width_reg;
        if (height_reg == '0)
            eff_h = DIM_ONE;
        else if (height_reg > H_CAP)
            eff_h = H_CAP;
        else
            eff_h = height_reg;
    end

    // APB: writes land only between frames.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && cmd.cfg_open && (pos_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_FRAME_WIDTH)
                width_reg <= pwdata[DIM_BITS-1:0];
            else
                height_reg <= pwdata[DIM_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_FRAME_WIDTH)
            prdata[DIM_BITS-1:0] = width_reg;
        else
            prdata[DIM_BITS-1:0] = height_reg;
    end

    // Raster position: linear address plus column and row for the borders.
    assign x_first = (x_reg == '0);
    assign y_first = (y_reg == '0);
    assign x_last  = (x_reg == X_BITS'(eff_w - DIM_ONE));
    assign y_last  = (y_reg == Y_BITS'(eff_h - DIM_ONE));

    always_comb
    begin
        pos_next = pos_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        case (cmd.pos_op)
            POS_CLEAR:
            begin
                pos_next = '0;
                x_next   = '0;
                y_next   = '0;
            end
            POS_INC:
            begin
                pos_next = pos_reg + ADDR_BITS'(1);
                if (x_last)
                begin
                    x_next = '0;
                    y_next = y_reg + Y_BITS'(1);
                end
                else
                    x_next = x_reg + X_BITS'(1);
            end
            POS_DEC:
            begin
                pos_next = pos_reg - ADDR_BITS'(1);
                if (x_first)
                begin
                    x_next = X_BITS'(eff_w - DIM_ONE);
                    y_next = y_reg - Y_BITS'(1);
                end
                else
                    x_next = x_reg - X_BITS'(1);
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            x_reg   <= '0;
            y_reg   <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    // Distance store: one write and one registered read per cycle.
    always_comb
    begin
        case (cmd.rd_sel)
            RD_TOP:  raddr = pos_reg - ADDR_BITS'(eff_w);
            RD_BOT:  raddr = pos_reg + ADDR_BITS'(eff_w);
            default: raddr = pos_reg;
        endcase
    end

    // Pass step: the side neighbor was computed one pixel earlier, the vertical one
    // comes from the store; borders read as background.
    always_comb
    begin
        if (cmd.pass_dir == DIR_FWD)
        begin
            side_v   = x_first ? '0 : nbr_reg;
            vert_v   = y_first ? '0 : rdata_reg;
            pass_val = dmin(sat_inc(side_v), sat_inc(vert_v));
        end
        else
        begin
            side_v   = x_last ? '0 : nbr_reg;
            vert_v   = y_last ? '0 : rdata_reg;
            pass_val = dmin(dmin(sat_inc(side_v), sat_inc(vert_v)), cur_reg);
        end
        if (cur_reg == '0)
            pass_val = '0;
    end

    assign mem_we    = cmd.load_write || cmd.pass_write;
    assign mem_wdata = cmd.load_write ? DIST_BITS'(pixel_on) : pass_val;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[pos_reg] <= mem_wdata;
        rdata_reg <= store_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cur_load)
            cur_reg <= rdata_reg;
        if (cmd.pass_write)
            nbr_reg <= pass_val;
    end

    // Result register: hold until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_kind)
                OUT_READ:
                begin
                    distance_reg <= rdata_reg;
                    last_reg     <= stat.at_last;
                    status_reg   <= 1'b0;
                end
                OUT_LOAD:
                begin
                    distance_reg <= '0;
                    last_reg     <= stat.at_last;
                    status_reg   <= 1'b0;
                end
                default:
                begin
                    distance_reg <= '0;
                    last_reg     <= 1'b0;
                    status_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign distance   = distance_reg;
    assign last_pixel = last_reg;
    assign status     = status_reg;

    assign stat.at_first = x_first && y_first;
    assign stat.at_last  = x_last && y_last;
    assign stat.out_free = !out_valid_reg || out_ready;

    a_x_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (DIM_BITS'(x_reg) < eff_w))
        else $error("column counter beyond frame width");

    a_y_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (DIM_BITS'(y_reg) < eff_h))
        else $error("row counter beyond frame height");

    a_pos_origin: assert property (@(posedge clk) disable iff (!rst_n)
        ((pos_reg == '0) == (x_reg == '0 && y_reg == '0)))
        else $error("linear position and column/row disagree at origin");

endmodule

[hdl/cbdt_ctrl.sv]
// Controller: phase and pass sequencing, input handshake, datapath commands.
// Depends on cbdt_pkg; drives cbdt_datapath.
`timescale 1ns / 1ps

module cbdt_ctrl
    import cbdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_cmd,
    output logic       in_ready,
    output cbdt_cmd_t  cmd,
    input  cbdt_stat_t stat
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_FWD_CUR,
        S_FWD_NBR,
        S_FWD_WR,
        S_REV_CUR,
        S_REV_NBR,
        S_REV_WR,
        S_READ,
        S_RD_DATA
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = ((state_reg == S_LOAD) || (state_reg == S_READ)) && stat.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.pos_op     = POS_HOLD;
        cmd.rd_sel     = RD_CUR;
        cmd.cur_load   = 1'b0;
        cmd.load_write = 1'b0;
        cmd.pass_write = 1'b0;
        cmd.pass_dir   = DIR_FWD;
        cmd.out_load   = 1'b0;
        cmd.out_kind   = OUT_REJECT;
        cmd.cfg_open   = (state_reg == S_LOAD);
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.out_load = 1'b1;
                    if (in_cmd == CMD_LOAD)
                    begin
                        cmd.load_write = 1'b1;
                        cmd.out_kind   = OUT_LOAD;
                        if (stat.at_last)
                        begin
                            cmd.pos_op = POS_CLEAR;
                            state_next = S_FWD_CUR;
                        end
                        else
                            cmd.pos_op = POS_INC;
                    end
                end
            end
            S_FWD_CUR:
            begin
                state_next = S_FWD_NBR;
            end
            S_FWD_NBR:
            begin
                cmd.rd_sel   = RD_TOP;
                cmd.cur_load = 1'b1;
                state_next   = S_FWD_WR;
            end
            S_FWD_WR:
            begin
                cmd.pass_write = 1'b1;
                // Reverse pass starts where the forward pass ends.
                if (stat.at_last)
                    state_next = S_REV_CUR;
                else
                begin
                    cmd.pos_op = POS_INC;
                    state_next = S_FWD_CUR;
                end
            end
            S_REV_CUR:
            begin
                cmd.pass_dir = DIR_REV;
                state_next   = S_REV_NBR;
            end
            S_REV_NBR:
            begin
                cmd.pass_dir = DIR_REV;
                cmd.rd_sel   = RD_BOT;
                cmd.cur_load = 1'b1;
                state_next   = S_REV_WR;
            end
            S_REV_WR:
            begin
                cmd.pass_dir   = DIR_REV;
                cmd.pass_write = 1'b1;
                if (stat.at_first)
                    state_next = S_READ;
                else
                begin
                    cmd.pos_op = POS_DEC;
                    state_next = S_REV_CUR;
                end
            end
            S_READ:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_READ)
                        state_next = S_RD_DATA;
                    else
                        cmd.out_load = 1'b1;
                end
            end
            S_RD_DATA:
            begin
                cmd.out_load = 1'b1;
                cmd.out_kind = OUT_READ;
                if (stat.at_last)
                begin
                    cmd.pos_op = POS_CLEAR;
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.pos_op = POS_INC;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load |-> stat.out_free))
        else $error("result register loaded while a word is still waiting");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_write && cmd.pass_write))
        else $error("load and pass write the store in the same cycle");

    a_read_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_DATA) |-> ($past(state_reg) == S_READ && $past(accept)))
        else $error("read data step without an accepted read word");

endmodule

[hdl/city_block_distance_transform.sv]
// Top level of the city-block distance transform: channels, APB port, controller
// and datapath. Depends on cbdt_pkg, cbdt_if, cbdt_ctrl and cbdt_datapath.
//
//  channel    dir  handshake      word
//  pixel_cmd  in   valid/ready    cmd, pixel_on
//  result     out  valid/ready    distance, last_pixel, status
//  apb        in   psel/penable   frame_width @0x0, frame_height @0x4
//
// A load or rejected word loads the result register on acceptance; a read goes via
// S_RD_DATA for the registered read of the single distance store. After the last load
// of a frame the two raster passes run with input ready low (three store accesses per
// pixel each pass). Reset clears control state only; the store is not cleared, as every
// entry is written before it is read. A waiting result word holds and blocks input.
`timescale 1ns / 1ps

module city_block_distance_transform
    import cbdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    cbdt_pix_if.sink              pixel_cmd,
    cbdt_res_if.source            result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    cbdt_cmd_t  cmd;
    cbdt_stat_t stat;

    cbdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel_cmd.valid),
        .in_cmd   (pixel_cmd.cmd),
        .in_ready (pixel_cmd.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    cbdt_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .pixel_on   (pixel_cmd.pixel_on),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .distance   (result.distance),
        .last_pixel (result.last_pixel),
        .status     (result.status)
    );

endmodule
